[hw/rtl/sfr_pkg.sv]
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

  localparam int unsigned MaxPattern     = 8;
  localparam int unsigned MaxReplacement = 8;
  localparam int unsigned WinDepth       = MaxPattern - 1;
  localparam int unsigned LenW           = 4;
  localparam int unsigned WinCntW        = 3;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned QDepth         = 2;
  localparam int unsigned QPtrW          = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatBytes = 2'd0,
    CfgPatLen   = 2'd1,
    CfgRepBytes = 2'd2,
    CfgRepLen   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } out_item_t;

  // Register values after range limiting.
  typedef struct packed {
    logic [8*MaxPattern-1:0]     pat_bytes;
    logic [LenW-1:0]             pat_len;
    logic [8*MaxReplacement-1:0] rep_bytes;
    logic [LenW-1:0]             rep_len;
  } cfg_t;

  // One request from the front to the back: literal bytes first, then replacement bytes.
  typedef struct packed {
    logic [8*MaxPattern-1:0] lits;
    logic [LenW-1:0]         lit_cnt;
    logic [LenW-1:0]         rep_cnt;
    logic                    fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/sfr_front.sv]
// Front end: accepts input bytes, tracks the pending prefix window and issues jobs.
module sfr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sfr_pkg::in_item_t in_data_i,
  input  logic             flush_i,
  input  sfr_pkg::cfg_t    cfg_i,
  input  sfr_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output sfr_pkg::job_t    job_o
);

  logic [7:0]                   win_q [sfr_pkg::WinDepth];
  logic [7:0]                   win_d [sfr_pkg::WinDepth];
  logic [sfr_pkg::WinCntW-1:0]  cnt_q, cnt_d;
  logic [7:0]                   cand [sfr_pkg::MaxPattern];
  logic [sfr_pkg::MaxPattern-1:0] ok;
  logic [sfr_pkg::WinCntW-1:0]  n;
  logic [sfr_pkg::LenW-1:0]     ntot, start, rest, lit_cnt, rep_cnt, plen_m1;
  logic                         match, accept, keep;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    plen_m1 = cfg_i.pat_len - sfr_pkg::LenW'(1);
    n = cnt_q;
    if ({1'b0, cnt_q} > plen_m1) begin
      n = plen_m1[sfr_pkg::WinCntW-1:0];
    end
    ntot = {1'b0, n} + sfr_pkg::LenW'(1);

    // Held bytes followed by the new byte.
    for (int i = 0; i < int'(sfr_pkg::MaxPattern); i++) begin
      cand[i] = in_data_i.data_byte;
    end
    for (int i = 0; i < int'(sfr_pkg::WinDepth); i++) begin
      if (i < int'(n)) begin
        cand[i] = win_q[i];
      end
    end

    // ok[s]: the candidate tail from position s is a prefix of the pattern.
    for (int s = 0; s < int'(sfr_pkg::MaxPattern); s++) begin
      if (s >= int'(ntot)) begin
        ok[s] = 1'b1;
      end else begin
        ok[s] = (int'(ntot) - s) <= int'(cfg_i.pat_len);
        for (int i = 0; i < int'(sfr_pkg::MaxPattern) - s; i++) begin
          if ((s + i < int'(ntot)) && (cand[s+i] != cfg_i.pat_bytes[8*i +: 8])) begin
            ok[s] = 1'b0;
          end
        end
      end
    end

    start = ntot;
    for (int s = int'(sfr_pkg::MaxPattern) - 1; s >= 0; s--) begin
      if (ok[s] && s < int'(ntot)) begin
        start = sfr_pkg::LenW'(s);
      end
    end

    rest  = ntot - start;
    match = (rest == cfg_i.pat_len);
    keep  = !match && !in_data_i.final_byte;

    lit_cnt = (!match && in_data_i.final_byte) ? ntot : start;
    rep_cnt = match ? cfg_i.rep_len : '0;

    for (int j = 0; j < int'(sfr_pkg::WinDepth); j++) begin
      win_d[j] = cand[sfr_pkg::WinCntW'(int'(start) + j)];
    end

    for (int i = 0; i < int'(sfr_pkg::MaxPattern); i++) begin
      job_o.lits[8*i +: 8] = cand[i];
    end
    job_o.lit_cnt = lit_cnt;
    job_o.rep_cnt = rep_cnt;
    job_o.fin     = in_data_i.final_byte;

    push_o = accept && ((lit_cnt + rep_cnt) != '0);

    cnt_d = cnt_q;
    if (flush_i) begin
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = keep ? rest[sfr_pkg::WinCntW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      win_q <= win_d;
    end
  end

endmodule

[hw/rtl/sfr_queue.sv]
// Short job queue between the front end and the output sequencer.
module sfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfr_pkg::job_t    job_i,
  input  logic             pop_i,
  output sfr_pkg::job_t    head_o,
  output sfr_pkg::q_stat_t stat_o
);

  sfr_pkg::job_t              mem_q [sfr_pkg::QDepth];
  logic [sfr_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sfr_pkg::QPtrW:0]    cnt_q, cnt_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (sfr_pkg::QPtrW+1)'(sfr_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + sfr_pkg::QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + sfr_pkg::QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (sfr_pkg::QPtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (sfr_pkg::QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[hw/rtl/sfr_back.sv]
// Output sequencer: walks the head job one byte per cycle into the output register when unstalled.
module sfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfr_pkg::job_t      head_i,
  input  sfr_pkg::q_stat_t   q_stat_i,
  input  sfr_pkg::cfg_t      cfg_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfr_pkg::out_item_t out_data_o
);

  logic [2:0]               idx_q, idx_d, ridx;
  logic [sfr_pkg::LenW-1:0] total;
  logic                     load, last, out_valid_q, out_valid_d;
  sfr_pkg::out_item_t       out_data_q, out_data_d;

  always_comb begin
    total = head_i.lit_cnt + head_i.rep_cnt;
    load  = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
    last  = ({1'b0, idx_q} == (total - sfr_pkg::LenW'(1)));
    ridx  = 3'({1'b0, idx_q} - head_i.lit_cnt);

    if ({1'b0, idx_q} < head_i.lit_cnt) begin
      out_data_d.out_byte = head_i.lits[{idx_q, 3'b000} +: 8];
    end else begin
      out_data_d.out_byte = cfg_i.rep_bytes[{ridx, 3'b000} +: 8];
    end
    out_data_d.run_last   = last;
    out_data_d.stream_end = last && head_i.fin;

    pop_o = load && last;
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + 3'd1;
    end
    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hw/rtl/stream_find_and_replace.sv]
// Top level of the stream find-and-replace block with its configuration registers.
// The first result of an input byte goes through the job queue and the output register.
// Results leave the output sequencer at one byte per cycle unless the output stalls; an
// input produces zero to eight results, and input is taken every cycle while the two-entry
// job queue has room. Reset is asynchronous and active low: it empties the window, the
// queue and the output register and sets pattern length 1, all other registers zero.
module stream_find_and_replace (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sfr_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sfr_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sfr_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [8*sfr_pkg::MaxPattern-1:0]     pat_bytes_q;
  logic [sfr_pkg::LenW-1:0]             pat_len_q;
  logic [8*sfr_pkg::MaxReplacement-1:0] rep_bytes_q;
  logic [sfr_pkg::LenW-1:0]             rep_len_q;
  sfr_pkg::cfg_t                        cfg;
  sfr_pkg::cfg_idx_e                    cfg_idx;
  sfr_pkg::job_t                        job, head;
  sfr_pkg::q_stat_t                     q_stat;
  logic                                 cfg_wr, flush, push, pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_idx     = sfr_pkg::cfg_idx_e'(cfg_index_i);
  assign flush       = cfg_wr && (cfg_idx == sfr_pkg::CfgPatBytes ||
                                  cfg_idx == sfr_pkg::CfgPatLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= sfr_pkg::LenW'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sfr_pkg::CfgPatBytes: pat_bytes_q <= cfg_data_i;
        sfr_pkg::CfgPatLen:   pat_len_q   <= cfg_data_i[sfr_pkg::LenW-1:0];
        sfr_pkg::CfgRepBytes: rep_bytes_q <= cfg_data_i;
        sfr_pkg::CfgRepLen:   rep_len_q   <= cfg_data_i[sfr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // A zero pattern length acts as one; lengths above the maximum saturate.
  always_comb begin
    cfg.pat_bytes = pat_bytes_q;
    cfg.rep_bytes = rep_bytes_q;
    cfg.pat_len   = pat_len_q;
    if (pat_len_q == '0) begin
      cfg.pat_len = sfr_pkg::LenW'(1);
    end else if (pat_len_q > sfr_pkg::LenW'(sfr_pkg::MaxPattern)) begin
      cfg.pat_len = sfr_pkg::LenW'(sfr_pkg::MaxPattern);
    end
    cfg.rep_len = rep_len_q;
    if (rep_len_q > sfr_pkg::LenW'(sfr_pkg::MaxReplacement)) begin
      cfg.rep_len = sfr_pkg::LenW'(sfr_pkg::MaxReplacement);
    end
  end

  sfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .flush_i    (flush),
    .cfg_i      (cfg),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (job)
  );

  sfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .cfg_i       (cfg),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The end of the text always closes the request's run of results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stream_end |-> out_data_o.run_last)
    else $error("stream_end without run_last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("job queue both full and empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

endmodule
